// ===== design/astcd_pkg.sv =====
// Package for the aux switch tap command decoder.
// Holds field widths, reset values, register indexes, guard codes, tap and countdown limits and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package astcd_pkg;

	localparam int TIME_W     = 32;
	localparam int DEBOUNCE_W = 10;
	localparam int PERIOD_W   = 14;
	localparam int WINDOW_W   = 6;
	localparam int TAP_W      = 8;
	localparam int GUARD_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(50);
	localparam logic [PERIOD_W-1:0]   PERIOD_RST   = PERIOD_W'(100);
	localparam logic [WINDOW_W-1:0]   WINDOW_RST   = WINDOW_W'(50);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TAP_DEBOUNCE = 2'd0,
		CFG_DECAY_PERIOD = 2'd1,
		CFG_WINDOW_RELOAD = 2'd2
	} cfg_idx_t;

	localparam logic [GUARD_W-1:0] GUARD_NONE     = 4'd0;
	localparam logic [GUARD_W-1:0] GUARD_TRIM     = 4'd4;
	localparam logic [GUARD_W-1:0] GUARD_TRIM_OFF = 4'd6;
	localparam logic [GUARD_W-1:0] GUARD_CAL      = 4'd8;
	localparam logic [GUARD_W-1:0] GUARD_TWELVE   = 4'd12;
	localparam logic [GUARD_W-1:0] GUARD_MAX      = 4'd13;

	localparam logic [TAP_W-1:0] TAP_TRIM = 8'd4;
	localparam logic [TAP_W-1:0] TAP_CAL  = 8'd8;

	localparam logic [WINDOW_W-1:0] CD_TRIM_MAX = 6'd25;
	localparam logic [WINDOW_W-1:0] CD_CAL_LO   = 6'd20;
	localparam logic [WINDOW_W-1:0] CD_CAL_HI   = 6'd40;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] tap_debounce_ms;
		logic [PERIOD_W-1:0]   decay_period_ms;
		logic [WINDOW_W-1:0]   window_reload;
	} cfg_t;

	typedef struct packed {
		logic              switch_on;
		logic [TIME_W-1:0] now_ms;
		logic              armed;
		logic              airplane_mode;
		logic              compass_calibrating;
		logic              auto_trim_in;
	} poll_t;

	typedef struct packed {
		logic               start_compass_cal;
		logic               auto_trim_out;
		logic               manual_trim_on;
		logic [GUARD_W-1:0] guard_code;
		logic [TAP_W-1:0]   tap_total;
	} res_t;

endpackage

// ===== design/astcd_poll_if.sv =====
// Poll channel: valid/ready handshake with the poll fields.
// Depends on astcd_pkg.
`timescale 1ns / 1ps

interface astcd_poll_if
	import astcd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              switch_on;
	logic [TIME_W-1:0] now_ms;
	logic              armed;
	logic              airplane_mode;
	logic              compass_calibrating;
	logic              auto_trim_in;

	modport source (output valid, switch_on, now_ms, armed, airplane_mode,
		compass_calibrating, auto_trim_in, input ready);
	modport sink (input valid, switch_on, now_ms, armed, airplane_mode,
		compass_calibrating, auto_trim_in, output ready);
	modport mon (input valid, ready, switch_on, now_ms, armed, airplane_mode,
		compass_calibrating, auto_trim_in);
endinterface

// ===== design/astcd_result_if.sv =====
// Result channel: valid/ready handshake with the decoder outputs.
// Depends on astcd_pkg.
`timescale 1ns / 1ps

interface astcd_result_if
	import astcd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               start_compass_cal;
	logic               auto_trim_out;
	logic               manual_trim_on;
	logic [GUARD_W-1:0] guard_code;
	logic [TAP_W-1:0]   tap_total;

	modport source (output valid, start_compass_cal, auto_trim_out, manual_trim_on,
		guard_code, tap_total, input ready);
	modport sink (input valid, start_compass_cal, auto_trim_out, manual_trim_on,
		guard_code, tap_total, output ready);
	modport mon (input valid, ready, start_compass_cal, auto_trim_out, manual_trim_on,
		guard_code, tap_total);
endinterface

// ===== design/astcd_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on astcd_pkg.
`timescale 1ns / 1ps

interface astcd_cfg_if
	import astcd_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/aux_switch_tap_command_decoder_unit.sv =====
// Aux switch tap command decoder, top level.
// Uses astcd_pkg, the channel interfaces, astcd_cfg_regs and astcd_core.
// Takes one poll per clock cycle while the result is not stalled. A poll is registered in
// the poll register, its whole state update (tap count, guard code, countdown and
// timestamps) is done from there, and its result is registered in the result register.
// The rate is set by the single-pass read-modify-write of the decoder state. A stalled
// result holds in the result register while one more poll is taken into the poll register.
// Configuration writes are always ready and must be issued while no poll is in flight.
`timescale 1ns / 1ps

module aux_switch_tap_command_decoder_unit
	import astcd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	astcd_cfg_if.sink      cfg,
	astcd_poll_if.sink     poll,
	astcd_result_if.source result
);

	cfg_t cfg_q;

	astcd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	astcd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.poll   (poll),
		.result (result)
	);

endmodule

// ===== design/astcd_cfg_regs.sv =====
// Configuration registers of the tap decoder, written through the cfg channel.
// Depends on astcd_pkg and astcd_cfg_if.
`timescale 1ns / 1ps

module astcd_cfg_regs
	import astcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	astcd_cfg_if.sink   cfg,
	output cfg_t        cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_debounce_ms <= DEBOUNCE_RST;
			cfg_q.decay_period_ms <= PERIOD_RST;
			cfg_q.window_reload   <= WINDOW_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TAP_DEBOUNCE:  cfg_q.tap_debounce_ms <= cfg.data[DEBOUNCE_W-1:0];
				CFG_DECAY_PERIOD:  cfg_q.decay_period_ms <= cfg.data[PERIOD_W-1:0];
				CFG_WINDOW_RELOAD: cfg_q.window_reload   <= cfg.data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/astcd_core.sv =====
// Decoder core: poll register, single-pass state update, result register.
// Depends on astcd_pkg, astcd_poll_if and astcd_result_if.
`timescale 1ns / 1ps

module astcd_core
	import astcd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	astcd_poll_if.sink    poll,
	astcd_result_if.source result
);

	logic  valid_s1;
	poll_t item_s1;
	logic  res_valid_q;
	res_t  res_q;
	logic  advance;

	logic [TAP_W-1:0]    tap_q;
	logic [GUARD_W-1:0]  guard_q;
	logic [WINDOW_W-1:0] cd_q;
	logic [TIME_W-1:0]   last_press_q;
	logic [TIME_W-1:0]   last_decay_q;
	logic                manual_q;

	logic [TIME_W-1:0]   press_gap;
	logic [TIME_W-1:0]   decay_gap;
	logic                press;
	logic                decay;
	logic [TAP_W-1:0]    tap_n;
	logic [GUARD_W-1:0]  guard_n;
	logic [WINDOW_W-1:0] cd_n;
	logic [TIME_W-1:0]   last_press_n;
	logic [TIME_W-1:0]   last_decay_n;
	logic                manual_n;
	logic                auto_n;
	logic                cal_n;
	logic                trim_win;
	logic                stray;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			item_s1.switch_on           <= poll.switch_on;
			item_s1.now_ms              <= poll.now_ms;
			item_s1.armed               <= poll.armed;
			item_s1.airplane_mode       <= poll.airplane_mode;
			item_s1.compass_calibrating <= poll.compass_calibrating;
			item_s1.auto_trim_in        <= poll.auto_trim_in;
		end
	end

	always_comb begin
		press_gap    = item_s1.now_ms - last_press_q;
		press        = item_s1.switch_on &&
			(press_gap > {{(TIME_W-DEBOUNCE_W){1'b0}}, cfg.tap_debounce_ms});
		tap_n        = press ? tap_q + TAP_W'(1) : tap_q;
		guard_n      = guard_q;
		if (press && guard_q >= GUARD_TRIM && guard_q <= GUARD_TWELVE) begin
			guard_n = guard_q + GUARD_W'(1);
		end
		cd_n         = item_s1.switch_on ? cfg.window_reload : cd_q;
		last_press_n = item_s1.switch_on ? item_s1.now_ms : last_press_q;

		decay_gap    = item_s1.now_ms - last_decay_q;
		decay        = (cd_n != '0) &&
			(decay_gap > {{(TIME_W-PERIOD_W){1'b0}}, cfg.decay_period_ms});
		last_decay_n = decay ? item_s1.now_ms : last_decay_q;
		if (decay) begin
			cd_n = cd_n - WINDOW_W'(1);
		end

		if (!item_s1.switch_on && (tap_n == TAP_CAL || cd_n == '0)) begin
			tap_n = '0;
		end
		if (item_s1.switch_on && tap_n == TAP_TRIM && !item_s1.compass_calibrating) begin
			guard_n = GUARD_TRIM;
		end
		if (item_s1.switch_on && tap_n == TAP_CAL) begin
			guard_n = GUARD_CAL;
		end

		trim_win = cd_n <= CD_TRIM_MAX;
		auto_n   = item_s1.auto_trim_in;
		manual_n = manual_q;
		cal_n    = 1'b0;
		if (item_s1.armed) begin
			if (guard_n == GUARD_TRIM && trim_win && item_s1.airplane_mode) begin
				auto_n = 1'b1;
			end
			if (guard_n == GUARD_TRIM_OFF && trim_win && item_s1.airplane_mode) begin
				auto_n  = 1'b0;
				guard_n = GUARD_NONE;
			end
		end else begin
			if (guard_n == GUARD_CAL && cd_n > CD_CAL_LO && cd_n < CD_CAL_HI) begin
				cal_n = 1'b1;
			end
			if (guard_n == GUARD_CAL && cd_n == CD_CAL_LO) begin
				guard_n = GUARD_NONE;
			end
			if (guard_n == GUARD_TRIM && trim_win && item_s1.airplane_mode && auto_n) begin
				guard_n = GUARD_NONE;
			end
			if (guard_n == GUARD_TRIM && trim_win) begin
				manual_n = 1'b1;
			end
			if (guard_n == GUARD_TRIM_OFF && trim_win) begin
				manual_n = 1'b0;
				guard_n  = GUARD_NONE;
			end
		end

		if (guard_n == GUARD_TWELVE && cd_n == '0) begin
			guard_n = (auto_n || manual_n) ? GUARD_TRIM : GUARD_NONE;
		end

		stray = guard_n <= GUARD_MAX && guard_n != GUARD_NONE && guard_n != GUARD_TRIM &&
			guard_n != GUARD_TRIM_OFF && guard_n != GUARD_CAL && guard_n != GUARD_TWELVE;
		if (cd_n == '0 && stray) begin
			guard_n = GUARD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q        <= '0;
			guard_q      <= '0;
			cd_q         <= '0;
			last_press_q <= '0;
			last_decay_q <= '0;
			manual_q     <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				tap_q        <= tap_n;
				guard_q      <= guard_n;
				cd_q         <= cd_n;
				last_press_q <= last_press_n;
				last_decay_q <= last_decay_n;
				manual_q     <= manual_n;
				res_valid_q  <= 1'b1;
			end else if (result.ready) begin
				res_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.start_compass_cal <= cal_n;
			res_q.auto_trim_out     <= auto_n;
			res_q.manual_trim_on    <= manual_n;
			res_q.guard_code        <= guard_n;
			res_q.tap_total         <= tap_n;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.start_compass_cal = res_q.start_compass_cal;
	assign result.auto_trim_out     = res_q.auto_trim_out;
	assign result.manual_trim_on    = res_q.manual_trim_on;
	assign result.guard_code        = res_q.guard_code;
	assign result.tap_total         = res_q.tap_total;

endmodule

// ===== design/astcd_checker.sv =====
// Port-level checker for the tap decoder, bound to the top level.
// Depends on astcd_pkg and the channel interfaces.
`timescale 1ns / 1ps

module astcd_checker
	import astcd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	astcd_poll_if.sink     poll,
	astcd_result_if.source result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid &&
		$stable(result.guard_code) && $stable(result.tap_total))
		else $error("result item changed while stalled");

	a_guard_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.guard_code <= GUARD_MAX)
		else $error("guard code out of range");

	a_cal_guard: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.start_compass_cal |-> result.guard_code == GUARD_CAL)
		else $error("calibration request without calibration guard");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(poll.valid && poll.ready, 2))
		else $error("result item without a poll");

endmodule

bind aux_switch_tap_command_decoder_unit astcd_checker u_astcd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.poll   (poll),
	.result (result)
);
